[src/tds_pkg.sv]
// ----------------------------------------------------------------------------
// Timer deadline scheduler package
// Result codes, request kinds and the fixed port widths that the scheduler and
// its checker share.
// ----------------------------------------------------------------------------
package tds_pkg;

  typedef enum logic [1:0] {
    StFired = 2'd0,
    StAdded = 2'd1,
    StFull  = 2'd2,
    StNone  = 2'd3
  } status_e;

  typedef enum logic {
    KindTick = 1'b0,
    KindAdd  = 1'b1
  } kind_e;

  localparam int unsigned TimeW    = 64;
  localparam int unsigned IdPortW  = 16;
  localparam int unsigned PendingW = 6;

  typedef logic [TimeW-1:0]    time_t;
  typedef logic [IdPortW-1:0]  id_port_t;
  typedef logic [PendingW-1:0] pend_t;

endpackage

[src/tds_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tds_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/timer_deadline_scheduler.sv]
// ----------------------------------------------------------------------------
// Timer deadline scheduler
// Table of pending one-shot and periodic timers, fired in deadline order.
// ----------------------------------------------------------------------------
// Usage. A request is taken when start_i is high and busy_o is low. An add
// request (kind_i = 1) inserts a timer and returns one result, status added or
// table full, in the next cycle; busy_o stays low, so adds may follow each
// other in every cycle. A tick request (kind_i = 0) sets the current time and
// then scans the table: each scan reads one table row per cycle from the single
// timer RAM, each fire adds a step for removal or re-arming, and a new scan
// follows each fire. A tick keeps busy_o high until its final scan ends, and
// its last result is shown in the first cycle in which busy_o is low again.
// Results of a tick appear one per strobe on valid_o, the last one with last_o
// set; a tick with nothing due gives one result, nothing due. Each result is
// shown for exactly one cycle and the receiver cannot stall it. Reset empties
// the table and sets the current time to zero; no clearing pass is needed since
// rows not marked valid are ignored whenever the scan reads them.
// ----------------------------------------------------------------------------
module timer_deadline_scheduler #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned MAX_FIRES   = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       kind_i,
  input  tds_pkg::time_t             time_value_i,
  input  logic                       relative_i,
  input  tds_pkg::time_t             interval_i,
  input  tds_pkg::id_port_t          entry_id_i,
  output logic                       valid_o,
  output logic [1:0]                 status_o,
  output tds_pkg::id_port_t          fired_id_o,
  output tds_pkg::time_t             fired_deadline_o,
  output logic                       last_o,
  output tds_pkg::pend_t             pending_o
);

  localparam int unsigned TW     = tds_pkg::TimeW;
  localparam int unsigned IdW    = (ID_BITS < tds_pkg::IdPortW) ? ID_BITS : tds_pkg::IdPortW;
  localparam int unsigned AddrW  = $clog2(TABLE_DEPTH);
  localparam int unsigned RankW  = AddrW;
  localparam int unsigned CntW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW     = $clog2(MAX_FIRES + 1);
  localparam int unsigned RowW   = 2 * TW + IdW + RankW;

  localparam logic [AddrW-1:0] LastIdx  = AddrW'(TABLE_DEPTH - 1);
  localparam logic [AddrW:0]   ScanEnd  = (AddrW + 1)'(TABLE_DEPTH);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFire
  } state_e;

  state_e                 state_q, state_d;
  tds_pkg::time_t         cur_time_q, cur_time_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [NW-1:0]          fires_q, fires_d;
  logic [AddrW:0]         scan_cnt_q, scan_cnt_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [AddrW-1:0]       rd_idx_q, rd_idx_d;
  logic                   fix_en_q, fix_en_d;
  logic                   fix_only_q, fix_only_d;
  logic [RankW-1:0]       rem_rank_q, rem_rank_d;
  logic                   skip_vld_q, skip_vld_d;
  logic [AddrW-1:0]       skip_slot_q, skip_slot_d;
  logic                   best_vld_q, best_vld_d;
  tds_pkg::time_t         best_dl_q, best_dl_d;
  tds_pkg::time_t         best_iv_q, best_iv_d;
  logic [IdW-1:0]         best_id_q, best_id_d;
  logic [RankW-1:0]       best_rank_q, best_rank_d;
  logic [AddrW-1:0]       best_slot_q, best_slot_d;
  logic [IdW-1:0]         held_id_q, held_id_d;
  tds_pkg::time_t         held_dl_q, held_dl_d;
  logic [CntW-1:0]        held_pend_q, held_pend_d;
  logic                   valid_out_q, valid_out_d;
  tds_pkg::status_e       status_q, status_d;
  tds_pkg::id_port_t      fired_id_q, fired_id_d;
  tds_pkg::time_t         fired_dl_q, fired_dl_d;
  logic                   last_q, last_d;
  tds_pkg::pend_t         pending_q, pending_d;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [RowW-1:0]        ram_wdata;
  logic [RowW-1:0]        ram_rdata;

  tds_pkg::time_t         r_dl;
  tds_pkg::time_t         r_iv;
  logic [IdW-1:0]         r_id;
  logic [RankW-1:0]       r_rank;
  logic [RankW-1:0]       rank_fix;
  logic                   ent_v;
  logic                   do_fix;
  logic                   due;
  logic                   better;
  logic [AddrW-1:0]       free_slot;
  tds_pkg::time_t         add_dl;

  tds_ram #(
    .Width(RowW),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(scan_cnt_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign r_dl   = ram_rdata[RowW-1 -: TW];
  assign r_iv   = ram_rdata[RowW-TW-1 -: TW];
  assign r_id   = ram_rdata[RankW +: IdW];
  assign r_rank = ram_rdata[RankW-1:0];

  // Lowest free row; only the fact that a row is free matters for ordering.
  always_comb begin
    free_slot = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = AddrW'(i);
      end
    end
  end

  // A removal is folded into the next pass: ranks above the removed one close
  // the gap as their rows go by, except the row that was just re-armed.
  assign ent_v    = rd_vld_q && valid_q[rd_idx_q];
  assign do_fix   = ent_v && fix_en_q && !(skip_vld_q && (skip_slot_q == rd_idx_q))
                    && (r_rank > rem_rank_q);
  assign rank_fix = do_fix ? (r_rank - 1'b1) : r_rank;
  assign due      = ent_v && !fix_only_q && (r_dl <= cur_time_q);
  assign better   = !best_vld_q || (r_dl < best_dl_q)
                    || ((r_dl == best_dl_q) && (rank_fix < best_rank_q));
  assign add_dl   = relative_i ? (cur_time_q + time_value_i) : time_value_i;

  always_comb begin
    state_d     = state_q;
    cur_time_d  = cur_time_q;
    valid_d     = valid_q;
    count_d     = count_q;
    fires_d     = fires_q;
    scan_cnt_d  = scan_cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    fix_en_d    = fix_en_q;
    fix_only_d  = fix_only_q;
    rem_rank_d  = rem_rank_q;
    skip_vld_d  = skip_vld_q;
    skip_slot_d = skip_slot_q;
    best_vld_d  = best_vld_q;
    best_dl_d   = best_dl_q;
    best_iv_d   = best_iv_q;
    best_id_d   = best_id_q;
    best_rank_d = best_rank_q;
    best_slot_d = best_slot_q;
    held_id_d   = held_id_q;
    held_dl_d   = held_dl_q;
    held_pend_d = held_pend_q;
    valid_out_d = 1'b0;
    status_d    = tds_pkg::StNone;
    fired_id_d  = '0;
    fired_dl_d  = '0;
    last_d      = 1'b0;
    pending_d   = tds_pkg::pend_t'(count_q);
    ram_we      = 1'b0;
    ram_waddr   = free_slot;
    ram_wdata   = {add_dl, interval_i, entry_id_i[IdW-1:0], RankW'(count_q)};

    case (state_q)
      StIdle: begin
        if (start_i) begin
          if (kind_i == tds_pkg::KindAdd) begin
            valid_out_d = 1'b1;
            last_d      = 1'b1;
            if (count_q == FullCnt) begin
              status_d = tds_pkg::StFull;
            end else begin
              status_d             = tds_pkg::StAdded;
              ram_we               = 1'b1;
              valid_d[free_slot]   = 1'b1;
              count_d              = count_q + 1'b1;
              pending_d            = tds_pkg::pend_t'(count_d);
            end
          end else begin
            cur_time_d = time_value_i;
            fires_d    = '0;
            fix_en_d   = 1'b0;
            fix_only_d = 1'b0;
            best_vld_d = 1'b0;
            scan_cnt_d = '0;
            state_d    = StScan;
          end
        end
      end

      StScan: begin
        if (scan_cnt_q != ScanEnd) begin
          rd_vld_d   = 1'b1;
          rd_idx_d   = scan_cnt_q[AddrW-1:0];
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
        if (do_fix) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_q;
          ram_wdata = {r_dl, r_iv, r_id, rank_fix};
        end
        if (due && better) begin
          best_vld_d  = 1'b1;
          best_dl_d   = r_dl;
          best_iv_d   = r_iv;
          best_id_d   = r_id;
          best_rank_d = rank_fix;
          best_slot_d = rd_idx_q;
        end
        if (rd_vld_q && (rd_idx_q == LastIdx)) begin
          if (fix_only_q || !best_vld_d) begin
            // The held fire is the final one; with none held, nothing was due.
            valid_out_d = 1'b1;
            last_d      = 1'b1;
            if (fires_q != '0) begin
              status_d   = tds_pkg::StFired;
              fired_id_d = tds_pkg::id_port_t'(held_id_q);
              fired_dl_d = held_dl_q;
              pending_d  = tds_pkg::pend_t'(held_pend_q);
            end
            fix_en_d = 1'b0;
            state_d  = StIdle;
          end else begin
            state_d = StFire;
          end
        end
      end

      StFire: begin
        // The previous fire is released now that another one follows it.
        if (fires_q != '0) begin
          valid_out_d = 1'b1;
          status_d    = tds_pkg::StFired;
          fired_id_d  = tds_pkg::id_port_t'(held_id_q);
          fired_dl_d  = held_dl_q;
          pending_d   = tds_pkg::pend_t'(held_pend_q);
        end
        held_id_d   = best_id_q;
        held_dl_d   = best_dl_q;
        skip_slot_d = best_slot_q;
        if (best_iv_q != '0) begin
          // Re-armed in its own row as the newest entry.
          ram_we      = 1'b1;
          ram_waddr   = best_slot_q;
          ram_wdata   = {best_dl_q + best_iv_q, best_iv_q, best_id_q,
                         RankW'(count_q - 1'b1)};
          skip_vld_d  = 1'b1;
          held_pend_d = count_q;
        end else begin
          valid_d[best_slot_q] = 1'b0;
          count_d              = count_q - 1'b1;
          skip_vld_d           = 1'b0;
          held_pend_d          = count_d;
        end
        fires_d    = fires_q + 1'b1;
        fix_en_d   = 1'b1;
        rem_rank_d = best_rank_q;
        fix_only_d = ((32'(fires_q) + 32'd1) == MAX_FIRES);
        best_vld_d = 1'b0;
        scan_cnt_d = '0;
        state_d    = StScan;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_time_q  <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      fires_q     <= '0;
      scan_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      fix_en_q    <= 1'b0;
      fix_only_q  <= 1'b0;
      skip_vld_q  <= 1'b0;
      best_vld_q  <= 1'b0;
      valid_out_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_time_q  <= cur_time_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      fires_q     <= fires_d;
      scan_cnt_q  <= scan_cnt_d;
      rd_vld_q    <= rd_vld_d;
      fix_en_q    <= fix_en_d;
      fix_only_q  <= fix_only_d;
      skip_vld_q  <= skip_vld_d;
      best_vld_q  <= best_vld_d;
      valid_out_q <= valid_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    rem_rank_q  <= rem_rank_d;
    skip_slot_q <= skip_slot_d;
    best_dl_q   <= best_dl_d;
    best_iv_q   <= best_iv_d;
    best_id_q   <= best_id_d;
    best_rank_q <= best_rank_d;
    best_slot_q <= best_slot_d;
    held_id_q   <= held_id_d;
    held_dl_q   <= held_dl_d;
    held_pend_q <= held_pend_d;
    status_q    <= status_d;
    fired_id_q  <= fired_id_d;
    fired_dl_q  <= fired_dl_d;
    last_q      <= last_d;
    pending_q   <= pending_d;
  end

  assign busy_o           = (state_q != StIdle);
  assign valid_o          = valid_out_q;
  assign status_o         = status_q;
  assign fired_id_o       = fired_id_q;
  assign fired_deadline_o = fired_dl_q;
  assign last_o           = last_q;
  assign pending_o        = pending_q;

endmodule

[src/tds_checker.sv]
// ----------------------------------------------------------------------------
// Timer deadline scheduler checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module tds_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              kind_i,
  input logic              valid_o,
  input logic [1:0]        status_o,
  input tds_pkg::id_port_t fired_id_o,
  input tds_pkg::time_t    fired_deadline_o,
  input logic              last_o
);

  // An add request is answered in the very next cycle with its only result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (kind_i == tds_pkg::KindAdd)) |=>
      (valid_o && last_o &&
       ((status_o == tds_pkg::StAdded) || (status_o == tds_pkg::StFull))))
    else $error("add request not answered in the next cycle");

  // A tick request always occupies the block while the table is scanned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (kind_i == tds_pkg::KindTick)) |=> busy_o)
    else $error("tick request did not start a scan");

  // Anything but a fire is a single, final result with empty payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o != tds_pkg::StFired)) |->
      (last_o && (fired_id_o == '0) && (fired_deadline_o == '0)))
    else $error("non-fire result is not a final empty result");

  // Once the final result is out, the block takes the next request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy_o)
    else $error("busy after the final result");

endmodule

bind timer_deadline_scheduler tds_checker u_tds_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .kind_i          (kind_i),
  .valid_o         (valid_o),
  .status_o        (status_o),
  .fired_id_o      (fired_id_o),
  .fired_deadline_o(fired_deadline_o),
  .last_o          (last_o)
);
